>>> hdl/hptr_pkg.sv
// ----------------------------------------------------------------------------
// Hex pair to two-row text: shared definitions
// Beat types, character constants, the mode encoding and the hex digit decode.
// ----------------------------------------------------------------------------
package hptr_pkg;

    localparam int DEFAULT_COLUMNS = 16;
    localparam int DEFAULT_ROWS    = 2;

    localparam int CHAR_W      = 8;
    localparam int NIBBLE_W    = 4;
    localparam int ROW_FIELD_W = 1;
    localparam int COL_FIELD_W = 4;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] PAD_GLYPH  = 8'h20;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              no_char;
        logic              end_of_message;
    } in_beat_t;

    typedef struct packed {
        logic [ROW_FIELD_W-1:0] row;
        logic [COL_FIELD_W-1:0] column;
        logic [CHAR_W-1:0]      glyph;
        logic                   last;
    } out_beat_t;

    typedef enum logic [3:0] {
        MODE_FIRST  = 4'b0001,
        MODE_SECOND = 4'b0010,
        MODE_SKIP   = 4'b0100,
        MODE_DONE   = 4'b1000
    } mode_t;

    // Any character that is not a hex digit counts as zero.
    function automatic logic [NIBBLE_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        d = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
        end
        return d[NIBBLE_W-1:0];
    endfunction

endpackage

>>> hdl/hptr_in_stage.sv
// ----------------------------------------------------------------------------
// Hex pair to two-row text: input register
// Holds one accepted input beat until the engine takes it.
// ----------------------------------------------------------------------------
module hptr_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  hptr_pkg::in_beat_t s_beat,
    input  logic               take,
    output logic               item_valid,
    output hptr_pkg::in_beat_t item_beat
);
    import hptr_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_beat_t beat_reg;

    // The register refills in the same cycle that the engine empties it.
    assign s_ready    = !valid_reg || take;
    assign valid_next = s_valid || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            beat_reg <= s_beat;
        end
    end

    assign item_valid = valid_reg;
    assign item_beat  = beat_reg;

endmodule

>>> hdl/hptr_engine.sv
// ----------------------------------------------------------------------------
// Hex pair to two-row text: engine
// Screen position and pairing state, item decode, padding run and result register.
// ----------------------------------------------------------------------------
module hptr_engine #(
    parameter int COLUMNS = hptr_pkg::DEFAULT_COLUMNS,
    parameter int ROWS    = hptr_pkg::DEFAULT_ROWS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    input  hptr_pkg::in_beat_t  item_beat,
    output logic                take,
    output logic                m_valid,
    input  logic                m_ready,
    output hptr_pkg::out_beat_t m_beat
);
    import hptr_pkg::*;

    localparam int RW = $clog2(ROWS + 1);
    localparam int CW = $clog2(COLUMNS + 1);
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);

    // Architectural state
    logic [RW-1:0]       cur_row_reg, cur_row_next;
    logic [CW-1:0]       cur_col_reg, cur_col_next;
    mode_t               mode_reg, mode_next;
    logic [NIBBLE_W-1:0] hi_reg, hi_next;

    // Padding run that follows the first result of an item
    logic          run_active_reg, run_active_next;
    logic          run_all_reg, run_all_next;
    logic [RW-1:0] run_row_reg, run_row_next;
    logic [CW-1:0] run_col_reg, run_col_next;

    logic      out_valid_reg, out_valid_next;
    out_beat_t out_beat_reg, out_beat_next;

    // Decode of the waiting item
    logic                has_char, is_space, is_comma, is_end;
    logic                emit_char, comma_pad, end_pad, first_valid;
    logic                skip_has_room;
    logic [RW-1:0]       first_row, adv_first_row;
    logic [CW-1:0]       first_col, adv_first_col;
    logic [CHAR_W-1:0]   first_glyph;
    logic                first_all, first_last;
    logic                run_last;
    logic                slot_free;

    assign has_char = !item_beat.no_char;
    assign is_space = has_char && (item_beat.char_code == CHAR_SPACE);
    assign is_comma = has_char && (item_beat.char_code == CHAR_COMMA);
    assign is_end   = item_beat.end_of_message;

    assign skip_has_room = (cur_row_reg < LAST_ROW);
    assign emit_char     = has_char && (mode_reg == MODE_SECOND);
    assign comma_pad     = is_comma && (mode_reg == MODE_FIRST);

    // End of message pads from the next free cell, unless every row is done.
    always_comb begin
        end_pad   = 1'b0;
        first_row = cur_row_reg;
        first_col = cur_col_reg;
        unique case (mode_reg)
            MODE_FIRST, MODE_SECOND: begin
                end_pad = is_end && !emit_char && !comma_pad;
            end
            MODE_SKIP: begin
                end_pad = is_end && skip_has_room;
                if (!emit_char && !comma_pad) begin
                    first_row = cur_row_reg + RW'(1);
                    first_col = '0;
                end
            end
            MODE_DONE: begin
                end_pad = 1'b0;
            end
            default: begin
                end_pad = 1'b0;
            end
        endcase
    end

    assign first_valid = emit_char || comma_pad || end_pad;
    assign first_glyph = emit_char ? {hi_reg, digit_value(item_beat.char_code)} : PAD_GLYPH;
    assign first_all   = emit_char || end_pad || is_end;
    assign first_last  = (emit_char && !is_end)
                      || ((first_col == LAST_COL) && (!first_all || first_row == LAST_ROW));

    assign adv_first_row = (first_col == LAST_COL) ? first_row + RW'(1) : first_row;
    assign adv_first_col = (first_col == LAST_COL) ? '0 : first_col + CW'(1);

    assign run_last  = (run_col_reg == LAST_COL) && (!run_all_reg || run_row_reg == LAST_ROW);
    assign slot_free = !out_valid_reg || m_ready;
    assign take      = item_valid && !run_active_reg && (slot_free || !first_valid);

    // Result register and padding run
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_beat_next   = out_beat_reg;
        run_active_next = run_active_reg;
        run_all_next    = run_all_reg;
        run_row_next    = run_row_reg;
        run_col_next    = run_col_reg;
        priority if (run_active_reg && slot_free) begin
            out_valid_next       = 1'b1;
            out_beat_next.row    = ROW_FIELD_W'(run_row_reg);
            out_beat_next.column = COL_FIELD_W'(run_col_reg);
            out_beat_next.glyph  = PAD_GLYPH;
            out_beat_next.last   = run_last;
            run_active_next      = !run_last;
            if (run_col_reg == LAST_COL) begin
                run_row_next = run_row_reg + RW'(1);
                run_col_next = '0;
            end else begin
                run_col_next = run_col_reg + CW'(1);
            end
        end else if (take && first_valid) begin
            out_valid_next       = 1'b1;
            out_beat_next.row    = ROW_FIELD_W'(first_row);
            out_beat_next.column = COL_FIELD_W'(first_col);
            out_beat_next.glyph  = first_glyph;
            out_beat_next.last   = first_last;
            run_active_next      = !first_last;
            run_all_next         = first_all;
            run_row_next         = adv_first_row;
            run_col_next         = adv_first_col;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Pairing state, updated when an item is taken
    always_comb begin
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        mode_next    = mode_reg;
        hi_next      = hi_reg;
        if (take) begin
            if (is_end) begin
                cur_row_next = '0;
                cur_col_next = '0;
                mode_next    = MODE_FIRST;
                hi_next      = '0;
            end else begin
                unique case (mode_reg)
                    MODE_FIRST: begin
                        if (is_comma) begin
                            cur_row_next = cur_row_reg + RW'(1);
                            cur_col_next = '0;
                            mode_next    = (cur_row_reg >= LAST_ROW) ? MODE_DONE : MODE_FIRST;
                        end else if (has_char && !is_space) begin
                            hi_next   = digit_value(item_beat.char_code);
                            mode_next = MODE_SECOND;
                        end
                    end
                    MODE_SECOND: begin
                        if (has_char) begin
                            cur_col_next = cur_col_reg + CW'(1);
                            mode_next    = (cur_col_reg >= LAST_COL) ? MODE_SKIP : MODE_FIRST;
                        end
                    end
                    MODE_SKIP: begin
                        if (is_comma) begin
                            cur_row_next = cur_row_reg + RW'(1);
                            cur_col_next = '0;
                            mode_next    = (cur_row_reg >= LAST_ROW) ? MODE_DONE : MODE_FIRST;
                        end
                    end
                    MODE_DONE: begin
                        mode_next = MODE_DONE;
                    end
                    default: begin
                        mode_next = MODE_FIRST;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            mode_reg       <= MODE_FIRST;
            hi_reg         <= '0;
            run_active_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            cur_row_reg    <= cur_row_next;
            cur_col_reg    <= cur_col_next;
            mode_reg       <= mode_next;
            hi_reg         <= hi_next;
            run_active_reg <= run_active_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        run_all_reg  <= run_all_next;
        run_row_reg  <= run_row_next;
        run_col_reg  <= run_col_next;
        out_beat_reg <= out_beat_next;
    end

    assign m_valid = out_valid_reg;
    assign m_beat  = out_beat_reg;

endmodule

>>> hdl/hex_pair_to_two_row_text.sv
// ----------------------------------------------------------------------------
// Hex pair to two-row text
// Turns a message of hex digit pairs into character writes for a text screen.
// ----------------------------------------------------------------------------
// Each input beat carries one message character. Pairs of hex digits become
// character writes with their row and column; a comma pads and ends the row,
// and the end of the message pads every cell not yet written, so one input
// beat can cause up to ROWS*COLUMNS result beats, the final one flagged by
// last. A beat passes an input register and then the result register, so its
// first result is shown on the cycle after it is taken into the engine. The
// engine takes one input beat and puts out one result per cycle while
// m_ready is high and no padding run is in progress; during a padding run
// the input side stalls once the input register holds a beat. Inputs that
// cause no result do not wait for m_ready, but they still wait until a
// padding run in progress has gone out.
module hex_pair_to_two_row_text #(
    parameter int COLUMNS = hptr_pkg::DEFAULT_COLUMNS,
    parameter int ROWS    = hptr_pkg::DEFAULT_ROWS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hptr_pkg::in_beat_t  s_beat,
    output logic                m_valid,
    input  logic                m_ready,
    output hptr_pkg::out_beat_t m_beat
);
    import hptr_pkg::*;

    logic     item_valid;
    in_beat_t item_beat;
    logic     take;

    hptr_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_beat     (s_beat),
        .take       (take),
        .item_valid (item_valid),
        .item_beat  (item_beat)
    );

    hptr_engine #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item_beat  (item_beat),
        .take       (take),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_beat     (m_beat)
    );

endmodule

>>> hdl/hptr_checker.sv
// ----------------------------------------------------------------------------
// Hex pair to two-row text: port checker
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
module hptr_checker #(
    parameter int COLUMNS = hptr_pkg::DEFAULT_COLUMNS,
    parameter int ROWS    = hptr_pkg::DEFAULT_ROWS
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input hptr_pkg::in_beat_t  s_beat,
    input logic                m_valid,
    input logic                m_ready,
    input hptr_pkg::out_beat_t m_beat
);
    import hptr_pkg::*;

    logic in_seen;
    assign in_seen = s_valid && s_ready && (s_beat.char_code == s_beat.char_code);

    // A stalled result beat holds its place and contents.
    a_out_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_beat))
        else $error("result beat changed while stalled");

    // A padding run streams without gaps once it has started.
    a_run_no_gap : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_beat.last |=> m_valid)
        else $error("gap inside a multi-beat result run");

    // Every beat after a non-final one is padding.
    a_run_is_pad : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_beat.last |=> m_beat.glyph == PAD_GLYPH)
        else $error("continuation beat is not padding");

    // Positions stay on the screen.
    a_on_screen : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid || in_seen |-> !m_valid
            || ((COLUMNS > 16 || m_beat.column < COLUMNS) && (ROWS > 1 || m_beat.row == 1'b0)))
        else $error("result position outside the screen");

endmodule

bind hex_pair_to_two_row_text hptr_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_beat  (s_beat),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_beat  (m_beat)
);
